@@ src/mvs_pkg.sv @@
// Shared types, constants and character classes for the version string scanner.
package mvs_pkg;

	localparam int unsigned TEXT_SIZE_DEF = 32;
	localparam int unsigned DIST_W        = 17;
	localparam int unsigned WIN_W         = 16;

	localparam logic [WIN_W-1:0]  WINDOW_RST  = 16'd512;
	localparam logic [DIST_W-1:0] DIST_MAX    = 17'h1FFFF;
	localparam logic [DIST_W-1:0] DIST_MARKER = 17'd3;
	localparam logic [23:0]       MARKER_HEAD = 24'h445856;
	localparam logic [7:0]        MARKER_TAIL = 8'h4B;
	localparam logic [1:0]        MAX_DOTS    = 2'd3;

	localparam logic [7:0] CH_V     = 8'h76;
	localparam logic [7:0] CH_DOT   = 8'h2E;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_UNDER = 8'h5F;
	localparam logic [7:0] CH_0     = 8'h30;
	localparam logic [7:0] CH_9     = 8'h39;
	localparam logic [7:0] CH_LA    = 8'h61;
	localparam logic [7:0] CH_LZ    = 8'h7A;
	localparam logic [7:0] CH_UA    = 8'h41;
	localparam logic [7:0] CH_UZ    = 8'h5A;

	typedef struct packed {
		logic start;
		logic not_found;
	} emit_cmd_t;

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= CH_0) && (b <= CH_9);
	endfunction

	function automatic logic is_tail_char(input logic [7:0] b);
		return is_digit(b) || ((b >= CH_LA) && (b <= CH_LZ)) ||
			((b >= CH_UA) && (b <= CH_UZ)) || (b == CH_DOT) ||
			(b == CH_DASH) || (b == CH_PLUS) || (b == CH_UNDER);
	endfunction

endpackage

@@ src/mvs_ram.sv @@
// Generic single-port-write, registered-read RAM.
module mvs_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

@@ src/mvs_scan.sv @@
// Marker tracking and version grammar parser, one byte per transaction.
module mvs_scan #(
	parameter int unsigned TEXT_SIZE = mvs_pkg::TEXT_SIZE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_wr_en,
	input  logic [mvs_pkg::WIN_W-1:0]        cfg_wr_data,
	input  logic                             accept,
	input  logic [7:0]                       data_byte,
	input  logic                             end_of_binary,
	output logic                             wr_en,
	output logic [$clog2(TEXT_SIZE)-1:0]     wr_addr,
	output logic [7:0]                       wr_data,
	output mvs_pkg::emit_cmd_t               cmd,
	output logic [$clog2(TEXT_SIZE+1)-1:0]   cmd_len
);
	import mvs_pkg::*;

	localparam int unsigned AW = $clog2(TEXT_SIZE);
	localparam int unsigned LW = $clog2(TEXT_SIZE + 1);
	localparam logic [LW-1:0] LEN_NUM_MAX  = LW'(TEXT_SIZE - 1);
	localparam logic [LW-1:0] LEN_TAIL_MAX = LW'(TEXT_SIZE - 2);

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_NUMBER,
		PH_TAIL,
		PH_DONE
	} phase_t;

	logic [WIN_W-1:0]  window_q;
	logic [23:0]       recent_q;
	logic              seen_q;
	logic [DIST_W-1:0] dist_q;
	phase_t            phase_q;
	logic [1:0]        dots_q;
	logic              hd_q;
	logic [LW-1:0]     len_q;
	logic              done_q;

	logic              seen_n;
	logic [DIST_W-1:0] dist_n;
	phase_t            phase_n;
	logic [1:0]        dots_n;
	logic              hd_n;
	logic [LW-1:0]     len_n;
	logic              done_n;
	logic              start_ok;
	logic              do_start;
	logic              do_tail;
	logic              do_append;
	logic              emit;
	logic              eob_emit;

	always_comb begin
		seen_n = seen_q;
		dist_n = dist_q;
		if (recent_q == MARKER_HEAD && data_byte == MARKER_TAIL) begin
			seen_n = 1'b1;
			dist_n = DIST_MARKER;
		end else if (seen_q && dist_q != DIST_MAX) begin
			dist_n = dist_q + DIST_W'(1);
		end
		start_ok = (data_byte == CH_V) && seen_n && (dist_n <= DIST_W'(window_q));

		phase_n   = phase_q;
		dots_n    = dots_q;
		hd_n      = hd_q;
		len_n     = len_q;
		done_n    = done_q;
		do_start  = 1'b0;
		do_tail   = 1'b0;
		do_append = 1'b0;
		emit      = 1'b0;

		unique case (phase_q)
			PH_IDLE: begin
				do_start = 1'b1;
			end
			PH_NUMBER: begin
				priority if (is_digit(data_byte)) begin
					if (len_q >= LEN_NUM_MAX) begin
						do_start = 1'b1;
					end else begin
						do_append = 1'b1;
						hd_n      = 1'b1;
					end
				end else if (!hd_q) begin
					do_start = 1'b1;
				end else if (data_byte == CH_DOT && dots_q != MAX_DOTS) begin
					if (len_q >= LEN_NUM_MAX) begin
						do_start = 1'b1;
					end else begin
						do_append = 1'b1;
						dots_n    = dots_q + 2'd1;
						hd_n      = 1'b0;
					end
				end else if (dots_q == 2'd0) begin
					do_start = 1'b1;
				end else begin
					do_tail = 1'b1;
				end
			end
			PH_TAIL: begin
				do_tail = 1'b1;
			end
			PH_DONE: begin
			end
			default: begin
			end
		endcase

		if (do_start) begin
			phase_n = start_ok ? PH_NUMBER : PH_IDLE;
			if (start_ok) begin
				len_n  = '0;
				dots_n = 2'd0;
				hd_n   = 1'b0;
			end
		end

		if (do_tail) begin
			phase_n = PH_TAIL;
			priority if (len_q >= LEN_TAIL_MAX) begin
				emit = 1'b1;
			end else if (is_tail_char(data_byte)) begin
				do_append = 1'b1;
				if (len_q + LW'(1) >= LEN_TAIL_MAX) begin
					emit = 1'b1;
				end
			end else begin
				emit = 1'b1;
			end
		end

		if (do_append) begin
			len_n = len_q + LW'(1);
		end

		if (emit) begin
			done_n  = 1'b1;
			phase_n = PH_DONE;
		end

		eob_emit = end_of_binary &&
			((phase_n == PH_NUMBER && hd_n && dots_n != 2'd0) || phase_n == PH_TAIL);
	end

	assign wr_en   = accept && do_append;
	assign wr_addr = len_q[AW-1:0];
	assign wr_data = data_byte;
	assign cmd_len = len_n;

	always_comb begin
		cmd.start     = accept && (emit || eob_emit);
		cmd.not_found = accept && end_of_binary && !(done_n || eob_emit);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RST;
			recent_q <= '0;
			seen_q   <= 1'b0;
			dist_q   <= '0;
			phase_q  <= PH_IDLE;
			dots_q   <= 2'd0;
			hd_q     <= 1'b0;
			len_q    <= '0;
			done_q   <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				window_q <= cfg_wr_data;
			end
			if (accept) begin
				if (end_of_binary) begin
					recent_q <= '0;
					seen_q   <= 1'b0;
					dist_q   <= '0;
					phase_q  <= PH_IDLE;
					dots_q   <= 2'd0;
					hd_q     <= 1'b0;
					len_q    <= '0;
					done_q   <= 1'b0;
				end else begin
					recent_q <= {recent_q[15:0], data_byte};
					seen_q   <= seen_n;
					dist_q   <= dist_n;
					phase_q  <= phase_n;
					dots_q   <= dots_n;
					hd_q     <= hd_n;
					len_q    <= len_n;
					done_q   <= done_n;
				end
			end
		end
	end

endmodule

@@ src/mvs_emit.sv @@
// Result sequencer: reads match text from the text memory and drives the output register.
module mvs_emit #(
	parameter int unsigned TEXT_SIZE = mvs_pkg::TEXT_SIZE_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mvs_pkg::emit_cmd_t               cmd,
	input  logic [$clog2(TEXT_SIZE+1)-1:0]   cmd_len,
	output logic                             in_ready,
	output logic                             rd_en,
	output logic [$clog2(TEXT_SIZE)-1:0]     rd_addr,
	input  logic [7:0]                       rd_data,
	output logic                             out_valid,
	input  logic                             out_ready,
	output logic [7:0]                       out_char,
	output logic                             out_found,
	output logic                             out_last
);
	import mvs_pkg::*;

	localparam int unsigned AW = $clog2(TEXT_SIZE);
	localparam int unsigned LW = $clog2(TEXT_SIZE + 1);

	logic          busy_q;
	logic [AW-1:0] idx_q;
	logic [LW-1:0] len_q;
	logic          v_s1;
	logic          nf_s1;
	logic          last_s1;
	logic          out_valid_q;
	logic [7:0]    out_char_q;
	logic          out_found_q;
	logic          out_last_q;
	logic          out_free;
	logic          idx_last;

	assign out_free = !out_valid_q || out_ready;
	assign rd_en    = busy_q && (!v_s1 || out_free);
	assign rd_addr  = idx_q;
	assign idx_last = (LW'(idx_q) == len_q - LW'(1));
	assign in_ready = !busy_q && (!v_s1 || out_free);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			idx_q       <= '0;
			len_q       <= '0;
			v_s1        <= 1'b0;
			nf_s1       <= 1'b0;
			last_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start) begin
				busy_q <= 1'b1;
				idx_q  <= '0;
				len_q  <= cmd_len;
			end else if (rd_en) begin
				busy_q <= !idx_last;
				idx_q  <= idx_q + AW'(1);
			end

			if (rd_en) begin
				v_s1    <= 1'b1;
				nf_s1   <= 1'b0;
				last_s1 <= idx_last;
			end else if (cmd.not_found) begin
				v_s1    <= 1'b1;
				nf_s1   <= 1'b1;
				last_s1 <= 1'b1;
			end else if (v_s1 && out_free) begin
				v_s1 <= 1'b0;
			end

			if (out_free) begin
				out_valid_q <= v_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && v_s1) begin
			out_char_q  <= nf_s1 ? 8'd0 : rd_data;
			out_found_q <= !nf_s1;
			out_last_q  <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_found = out_found_q;
	assign out_last  = out_last_q;

endmodule

@@ src/marker_version_string_scanner_core.sv @@
// Top level of the marker-anchored version string scanner.
// The scanner takes one byte per clock cycle. A byte that completes a version match
// starts a result run: the matched text (without the leading v) is read from the text
// memory one character per cycle while the output is not held, and input stalls until
// all of its characters (at most TEXT_SIZE-1) are read; a held output stalls it too.
// The end-of-binary byte without a match gives a single not-found result with found
// low and data zero. The output register lets the next byte be taken while a result
// waits.
// There is no clearing pass after reset; the marker window register resets to 512.
module marker_version_string_scanner_core #(
	parameter int unsigned TEXT_SIZE = mvs_pkg::TEXT_SIZE_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [mvs_pkg::WIN_W-1:0] cfg_wr_data,   // marker_window
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [7:0]                s_tdata,       // [7:0] data_byte
	input  logic                      s_tlast,       // end_of_binary
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [7:0]                m_tdata,       // [7:0] version_char
	output logic                      m_tuser,       // [0] found
	output logic                      m_tlast        // run_last
);
	import mvs_pkg::*;

	localparam int unsigned AW = $clog2(TEXT_SIZE);
	localparam int unsigned LW = $clog2(TEXT_SIZE + 1);

	logic          accept;
	logic          wr_en;
	logic [AW-1:0] wr_addr;
	logic [7:0]    wr_data;
	logic          rd_en;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;
	emit_cmd_t     cmd;
	logic [LW-1:0] cmd_len;

	assign accept = s_tvalid && s_tready;

	mvs_scan #(.TEXT_SIZE(TEXT_SIZE)) u_scan (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_wr_en     (cfg_wr_en),
		.cfg_wr_data   (cfg_wr_data),
		.accept        (accept),
		.data_byte     (s_tdata),
		.end_of_binary (s_tlast),
		.wr_en         (wr_en),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.cmd           (cmd),
		.cmd_len       (cmd_len)
	);

	mvs_ram #(.WIDTH(8), .DEPTH(TEXT_SIZE)) u_text (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	mvs_emit #(.TEXT_SIZE(TEXT_SIZE)) u_emit (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cmd_len   (cmd_len),
		.in_ready  (s_tready),
		.rd_en     (rd_en),
		.rd_addr   (rd_addr),
		.rd_data   (rd_data),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_char  (m_tdata),
		.out_found (m_tuser),
		.out_last  (m_tlast)
	);

endmodule

@@ src/mvs_chk.sv @@
// Port-level checker for the scanner top level, with its bind.
module mvs_chk (
	input logic       clk,
	input logic       arst_n,
	input logic       s_tready,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tuser,
	input logic       m_tlast
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser) &&
			$stable(m_tlast))
		else $error("output transaction changed while stalled");

	a_miss_form: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser |-> m_tlast && m_tdata == 8'd0)
		else $error("not-found result malformed");

	a_run_stall: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser && !m_tlast && !m_tready |-> !s_tready)
		else $error("input taken while a result run is blocked");

	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tready && m_tuser && !m_tlast |=> m_tvalid && m_tuser)
		else $error("result run broken");

endmodule

bind marker_version_string_scanner_core mvs_chk u_mvs_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);

@@ test/mvs_result_checker.sv @@
// Result checker for the version string scanner: predicts each result run and compares.
`timescale 1ns / 100ps
module mvs_result_checker #(
	parameter int unsigned TEXT_SIZE = mvs_pkg::TEXT_SIZE_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wr_en,
	input  logic [mvs_pkg::WIN_W-1:0] cfg_wr_data,
	input  logic                      s_tvalid,
	input  logic                      s_tready,
	input  logic [7:0]                s_tdata,
	input  logic                      s_tlast,
	input  logic                      m_tvalid,
	input  logic                      m_tready,
	input  logic [7:0]                m_tdata,
	input  logic                      m_tuser,
	input  logic                      m_tlast,
	output int                        outstanding,
	output int                        mismatches
);
	import mvs_pkg::*;

	localparam int unsigned AW = $clog2(TEXT_SIZE);

	typedef enum logic [2:0] {
		SCAN_IDLE,
		SCAN_NUMBER,
		SCAN_TAIL,
		SCAN_DONE
	} scan_phase_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       found;
		logic       last;
	} version_result_t;

	version_result_t   expected_runs[$];
	logic [WIN_W-1:0]  window_q;
	logic [23:0]       history;
	logic              marker_armed;
	logic [DIST_W-1:0] marker_dist;
	scan_phase_t       phase;
	logic [1:0]        dots;
	logic              group_digit;
	logic [6:0]        text_len;
	logic [7:0]        text_mem [TEXT_SIZE];
	logic              matched;

	function automatic logic digit_char(input logic [7:0] b);
		return (b >= CH_0) && (b <= CH_9);
	endfunction

	function automatic logic tail_class(input logic [7:0] b);
		logic [7:0] folded;
		folded = b | 8'h20;
		return digit_char(b) || ((folded >= CH_LA) && (folded <= CH_LZ)) ||
			(b == CH_DOT) || (b == CH_DASH) || (b == CH_PLUS) || (b == CH_UNDER);
	endfunction

	task automatic clear_scan();
		history      = '0;
		marker_armed = 1'b0;
		marker_dist  = '0;
		phase        = SCAN_IDLE;
		dots         = '0;
		group_digit  = 1'b0;
		text_len     = '0;
		matched      = 1'b0;
	endtask

	task automatic open_candidate(input logic [7:0] b);
		phase = SCAN_IDLE;
		if (b == CH_V && marker_armed && marker_dist <= {1'b0, window_q}) begin
			phase       = SCAN_NUMBER;
			text_len    = '0;
			dots        = '0;
			group_digit = 1'b0;
		end
	endtask

	task automatic append_text(input logic [7:0] b);
		if (text_len < TEXT_SIZE) begin
			text_mem[text_len[AW-1:0]] = b;
			text_len++;
		end
	endtask

	task automatic release_text();
		version_result_t r;
		for (int k = 0; k < text_len; k++) begin
			r.ch    = text_mem[k];
			r.found = 1'b1;
			r.last  = (k + 1 == text_len);
			expected_runs.push_back(r);
		end
		matched = 1'b1;
		phase   = SCAN_DONE;
	endtask

	task automatic tail_step(input logic [7:0] b);
		if (text_len >= TEXT_SIZE - 2) begin
			release_text();
		end else if (tail_class(b)) begin
			append_text(b);
			if (text_len >= TEXT_SIZE - 2)
				release_text();
		end else begin
			release_text();
		end
	endtask

	task automatic scan_byte(input logic [7:0] b, input logic eob);
		version_result_t miss;
		if (history == MARKER_HEAD && b == MARKER_TAIL) begin
			marker_armed = 1'b1;
			marker_dist  = DIST_MARKER;
		end else if (marker_armed && marker_dist != DIST_MAX) begin
			marker_dist++;
		end
		history = {history[15:0], b};

		case (phase)
			SCAN_IDLE: begin
				open_candidate(b);
			end
			SCAN_NUMBER: begin
				if (digit_char(b)) begin
					if (text_len >= TEXT_SIZE - 1) begin
						open_candidate(b);
					end else begin
						append_text(b);
						group_digit = 1'b1;
					end
				end else if (!group_digit) begin
					open_candidate(b);
				end else if (b == CH_DOT && dots < MAX_DOTS) begin
					if (text_len >= TEXT_SIZE - 1) begin
						open_candidate(b);
					end else begin
						append_text(b);
						dots++;
						group_digit = 1'b0;
					end
				end else if (dots == 0) begin
					open_candidate(b);
				end else begin
					phase = SCAN_TAIL;
					tail_step(b);
				end
			end
			SCAN_TAIL: begin
				tail_step(b);
			end
			default: begin
			end
		endcase

		if (eob) begin
			if ((phase == SCAN_NUMBER && group_digit && dots != 0) || phase == SCAN_TAIL)
				release_text();
			if (!matched) begin
				miss.ch    = 8'h00;
				miss.found = 1'b0;
				miss.last  = 1'b1;
				expected_runs.push_back(miss);
			end
			clear_scan();
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		version_result_t want;
		if (!arst_n) begin
			window_q = WINDOW_RST;
			clear_scan();
			expected_runs.delete();
			outstanding <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (expected_runs.size() == 0) begin
					$error("unexpected result: version_char %h, found %b, run_last %b",
						m_tdata, m_tuser, m_tlast);
					mismatches++;
				end else begin
					want = expected_runs.pop_front();
					if (m_tdata !== want.ch) begin
						$error("version_char: expected %h, got %h", want.ch, m_tdata);
						mismatches++;
					end
					if (m_tuser !== want.found) begin
						$error("found: expected %b, got %b", want.found, m_tuser);
						mismatches++;
					end
					if (m_tlast !== want.last) begin
						$error("run_last: expected %b, got %b", want.last, m_tlast);
						mismatches++;
					end
				end
			end
			if (cfg_wr_en)
				window_q = cfg_wr_data;
			if (s_tvalid && s_tready)
				scan_byte(s_tdata, s_tlast);
			outstanding <= expected_runs.size();
		end
	end

endmodule

@@ test/tb_marker_version_string_scanner_core.sv @@
// Testbench top for the version string scanner: byte stimulus, back-pressure and verdict.
`timescale 1ns / 100ps
module tb_marker_version_string_scanner_core;
	import mvs_pkg::*;

	localparam int SETTLE       = TEXT_SIZE_DEF + 8;
	localparam int RANDOM_ITEMS = 320;
	localparam int PHASES       = 8;

	logic             clk;
	logic             arst_n      = 1'b0;
	logic             cfg_wr_en   = 1'b0;
	logic [WIN_W-1:0] cfg_wr_data = '0;
	logic             s_tvalid    = 1'b0;
	logic             s_tready;
	logic [7:0]       s_tdata     = 8'h00;   // [7:0] data_byte
	logic             s_tlast     = 1'b0;    // end_of_binary
	logic             m_tvalid;
	logic             m_tready    = 1'b0;
	logic [7:0]       m_tdata;               // [7:0] version_char
	logic             m_tuser;               // [0] found
	logic             m_tlast;               // run_last

	int               outstanding;
	int               mismatches;
	logic [7:0]       image_bytes[$];
	int               items_sent  = 0;
	int               send_calm   = 0;
	int               recv_calm   = 0;
	logic [WIN_W-1:0] window_now  = WINDOW_RST;

	marker_version_string_scanner_core #(
		.TEXT_SIZE(TEXT_SIZE_DEF)
	) DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

	mvs_result_checker #(
		.TEXT_SIZE(TEXT_SIZE_DEF)
	) u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tlast    (s_tlast),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast),
		.outstanding(outstanding),
		.mismatches (mismatches)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#30_000_000;
		$display("FAILED: results differ");
		$finish;
	end

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 7))
			0: return CH_V;
			1: return 8'(CH_0 + $urandom_range(0, 9));
			2: return CH_DOT;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [7:0] tail_pick();
		case ($urandom_range(0, 6))
			0: return CH_DASH;
			1: return CH_PLUS;
			2: return CH_UNDER;
			3: return CH_DOT;
			4: return 8'(CH_UA + $urandom_range(0, 25));
			5: return 8'(CH_0 + $urandom_range(0, 9));
			default: return 8'(CH_LA + $urandom_range(0, 25));
		endcase
	endfunction

	task automatic push_noise(input int n);
		repeat (n) image_bytes.push_back(noise_byte());
	endtask

	task automatic push_digits(input int n);
		repeat (n) image_bytes.push_back(8'(CH_0 + $urandom_range(0, 9)));
	endtask

	task automatic push_marker();
		image_bytes.push_back(MARKER_HEAD[23:16]);
		image_bytes.push_back(MARKER_HEAD[15:8]);
		image_bytes.push_back(MARKER_HEAD[7:0]);
		image_bytes.push_back(MARKER_TAIL);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			image_bytes.push_back(s[i]);
	endtask

	task automatic send_image(input bit no_gap);
		int gap;
		for (int i = 0; i < image_bytes.size(); i++) begin
			if (no_gap) begin
				gap = 0;
			end else if (send_calm > 0) begin
				send_calm--;
				gap = 0;
			end else if ($urandom_range(0, 15) == 0) begin
				send_calm = $urandom_range(8, 30);
				gap = 0;
			end else begin
				gap = $urandom_range(0, 10);
			end
			if (gap > 0) begin
				s_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= image_bytes[i];
			s_tlast  <= (i == image_bytes.size() - 1);
			@(posedge clk);
			while (!s_tready) @(posedge clk);
		end
		items_sent += image_bytes.size();
		image_bytes.delete();
	endtask

	task automatic set_window(input logic [WIN_W-1:0] w);
		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (SETTLE) @(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= w;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		window_now = w;
	endtask

	task automatic build_random_image();
		int gap;
		int lead;
		int total;
		push_noise($urandom_range(0, 5));
		if ($urandom_range(0, 7) == 0) begin
			image_bytes.push_back(MARKER_HEAD[23:16]);
			image_bytes.push_back(MARKER_HEAD[15:8]);
			image_bytes.push_back(noise_byte());
		end else begin
			push_marker();
		end
		if (window_now <= 40 && $urandom_range(0, 1) == 1) begin
			gap = int'(window_now) - 5 + $urandom_range(0, 2);
			if (gap < 0)
				gap = 0;
		end else begin
			gap = $urandom_range(0, 6);
		end
		push_noise(gap);
		image_bytes.push_back(CH_V);
		case ($urandom_range(0, 9))
			0: begin
				lead  = $urandom_range(1, 8);
				total = $urandom_range(TEXT_SIZE_DEF - 2, TEXT_SIZE_DEF + 1);
				push_digits(lead);
				image_bytes.push_back(CH_DOT);
				push_digits(total - lead - 1);
			end
			1: begin
				push_digits($urandom_range(1, 3));
				image_bytes.push_back(CH_DOT);
				push_digits($urandom_range(1, 2));
				repeat ($urandom_range(20, 30)) image_bytes.push_back(tail_pick());
			end
			2: begin
				push_digits($urandom_range(0, 4));
			end
			default: begin
				push_digits($urandom_range(1, 3));
				repeat ($urandom_range(1, 4)) begin
					image_bytes.push_back(CH_DOT);
					push_digits(($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 3));
				end
				repeat ($urandom_range(0, 6)) image_bytes.push_back(tail_pick());
			end
		endcase
		if ($urandom_range(0, 3) != 0)
			image_bytes.push_back(noise_byte());
		push_noise($urandom_range(0, 3));
	endtask

	initial begin
		int stall;
		@(posedge clk);
		forever begin
			if (recv_calm > 0) begin
				recv_calm--;
				stall = 0;
			end else if ($urandom_range(0, 15) == 0) begin
				recv_calm = $urandom_range(8, 30);
				stall = 0;
			end else begin
				stall = $urandom_range(0, 10);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	initial begin
		logic [WIN_W-1:0] w;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		set_window(WINDOW_RST);

		push_text("v1.2");
		send_image(1'b0);
		image_bytes.push_back(8'hFF);
		push_marker();
		push_text("vv1.2");
		send_image(1'b0);
		push_marker();
		push_text("v1.2.3.4-_+Z");
		image_bytes.push_back(8'h00);
		send_image(1'b1);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: w = 16'd4;
				1: w = 16'd0;
				2: w = 16'd20;
				3: w = 16'hFFFF;
				4: w = 16'd5;
				5: w = WINDOW_RST;
				6: w = 16'd3;
				default: w = 16'($urandom_range(0, 65535));
			endcase
			set_window(w);
			while (items_sent < (p + 1) * RANDOM_ITEMS / PHASES) begin
				build_random_image();
				send_image(1'b0);
			end
		end

		s_tvalid <= 1'b0;
		@(posedge clk);
		wait (outstanding == 0);
		repeat (SETTLE) @(posedge clk);
		if (mismatches == 0 && outstanding == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

endmodule

@@ filelist.f @@
src/mvs_pkg.sv
src/mvs_ram.sv
src/mvs_scan.sv
src/mvs_emit.sv
src/marker_version_string_scanner_core.sv
src/mvs_chk.sv
test/mvs_result_checker.sv
test/tb_marker_version_string_scanner_core.sv
